// ----- hdl/midi_file_note_extractor_defines.svh -----
// ----------------------------------------------------------------------------
// midi_file_note_extractor_defines
// assertion macros for the midi file note extractor
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_NOTE_EXTRACTOR_DEFINES_SVH
`define MIDI_FILE_NOTE_EXTRACTOR_DEFINES_SVH
// property that must hold after reset
`define MFNE_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("assertion failed");
// implication checked next cycle
`define MFNE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hdl/mfne_pkg.sv -----
// ----------------------------------------------------------------------------
// mfne_pkg
// shared types and constants of the midi file note extractor
// ----------------------------------------------------------------------------
`default_nettype none
package mfne_pkg;
	localparam logic [31:0] MAGIC_FILE  = 32'h4d546864;
	localparam logic [31:0] MAGIC_TRACK = 32'h4d54726b;
	localparam logic [15:0] MAX_EVENTS_RST  = 16'd1024;
	localparam logic [15:0] TRACK_LIMIT_RST = 16'd2;

	localparam logic [2:0] K_NOTE  = 3'd0;
	localparam logic [2:0] K_TPB   = 3'd1;
	localparam logic [2:0] K_TEMPO = 3'd2;
	localparam logic [2:0] K_NAME  = 3'd3;
	localparam logic [2:0] K_DONE  = 3'd4;
	localparam logic [2:0] K_NOFILE = 3'd5;

	localparam logic [4:0] PH_MAGIC = 5'd0;
	localparam logic [4:0] PH_HLEN = 5'd1;
	localparam logic [4:0] PH_FORMAT = 5'd2;
	localparam logic [4:0] PH_NTRK = 5'd3;
	localparam logic [4:0] PH_DIV = 5'd4;
	localparam logic [4:0] PH_CMAGIC = 5'd5;
	localparam logic [4:0] PH_CLEN = 5'd6;
	localparam logic [4:0] PH_DELTA = 5'd7;
	localparam logic [4:0] PH_STATUS = 5'd8;
	localparam logic [4:0] PH_DATA1 = 5'd9;
	localparam logic [4:0] PH_DATA2 = 5'd10;
	localparam logic [4:0] PH_SYSEX_LEN = 5'd11;
	localparam logic [4:0] PH_META_TYPE = 5'd12;
	localparam logic [4:0] PH_META_LEN = 5'd13;
	localparam logic [4:0] PH_SKIP = 5'd14;
	localparam logic [4:0] PH_NAME = 5'd15;
	localparam logic [4:0] PH_TEMPO = 5'd16;
	localparam logic [4:0] PH_IDLE = 5'd17;

	localparam logic [0:0] REG_MAX_EVENTS  = 1'd0;
	localparam logic [0:0] REG_TRACK_LIMIT = 1'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] delta;
		logic [7:0]  status_byte;
		logic [7:0]  note;
		logic [7:0]  velocity;
		logic [23:0] value;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} step_out_t;
endpackage
`default_nettype wire

// ----- hdl/mfne_out_queue.sv -----
// ----------------------------------------------------------------------------
// mfne_out_queue
// four entry result queue with per-byte run marking
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_file_note_extractor_defines.svh"
module mfne_out_queue
	import mfne_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire step_out_t  push_data,
	output logic            room2,
	output logic            empty,
	input  wire logic       pop,
	output res_t            head,
	output logic            head_last
);
	res_t       mem_q [4];
	logic [3:0] last_q;
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;

	assign n_push = push ? push_data.cnt : 2'd0;
	assign room2  = cnt_q <= 3'd2;
	assign empty  = cnt_q == 3'd0;
	assign head   = mem_q[rd_q];
	assign head_last = last_q[rd_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= push_data.r0;
			if (n_push == 2'd2)
				mem_q[wr_q + 2'd1] <= push_data.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			last_q <= '0;
		end else begin
			if (n_push == 2'd1) last_q[wr_q] <= 1'b1;
			if (n_push == 2'd2) begin
				last_q[wr_q] <= 1'b0;
				last_q[wr_q + 2'd1] <= 1'b1;
			end
			wr_q <= wr_q + n_push;
			rd_q <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, pop};
		end
	end

	`MFNE_ASSERT(a_no_overflow, clk, arst_n, (cnt_q <= 3'd4))
	`MFNE_ASSERT(a_pop_nonempty, clk, arst_n, (!pop || cnt_q != 3'd0))
	`MFNE_ASSERT_NEXT(a_cnt_track, clk, arst_n, (n_push == 2'd0 && !pop),
		(cnt_q == $past(cnt_q)))
endmodule
`default_nettype wire

// ----- hdl/midi_file_note_extractor.sv -----
// ----------------------------------------------------------------------------
// midi_file_note_extractor
// byte-serial standard midi file parser emitting notes, tempo and names
// ----------------------------------------------------------------------------
// results: written into the output queue as their byte is accepted
// throughput: one byte per cycle while the result queue has room for two
// up to two results per byte drain one per cycle from a four entry queue while out_ready is high
// reset: asynchronous, parser waits for file magic, registers at defaults
`default_nettype none
`include "midi_file_note_extractor_defines.svh"
module midi_file_note_extractor
	import mfne_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [31:0]      delta,
	output logic [7:0]       status_byte,
	output logic [7:0]       note,
	output logic [7:0]       velocity,
	output logic [23:0]      value,
	output logic             last_of_run,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [15:0] max_events_q, track_limit_q;
	logic [4:0]  phase_q;
	logic [31:0] acc_q, tlen_q, used_q, edelta_q, skip_q;
	logic [2:0]  left_q;
	logic [15:0] ntrk_q, chunk_q, evcnt_q;
	logic [7:0]  rs_q, cs_q, fd_q, mt_q;
	logic        tempo_q;

	logic [4:0]  ph_n;
	logic [31:0] acc_n, tlen_n, used_n, edelta_n, skip_n;
	logic [2:0]  left_n;
	logic [15:0] ntrk_n, chunk_n, evcnt_n;
	logic [7:0]  rs_n, cs_n, fd_n, mt_n;
	logic        tempo_n;

	logic [4:0]  ph_c;
	logic [31:0] acc_c, tlen_c, used_c, fa, va;
	logic [2:0]  left_c, fl;
	logic [15:0] ntrk_c, chunk_c, evcnt_c;
	logic [7:0]  rs_c;
	logic        tempo_c, fdone, vdone;
	logic [7:0]  b;
	logic [3:0]  hi;

	step_out_t   so;
	logic        q_room, q_empty, accept;
	res_t        head;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'd0, track_limit_q} : {16'd0, max_events_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_events_q <= MAX_EVENTS_RST;
			track_limit_q <= TRACK_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MAX_EVENTS: max_events_q <= pwdata[15:0];
				REG_TRACK_LIMIT: track_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_ready = q_room;
	assign accept = in_valid && in_ready;
	assign b = data_byte;

	always_comb begin
		ph_c = first_byte ? PH_MAGIC : phase_q;
		acc_c = first_byte ? '0 : acc_q;
		left_c = first_byte ? 3'd4 : left_q;
		ntrk_c = first_byte ? '0 : ntrk_q;
		chunk_c = first_byte ? '0 : chunk_q;
		tlen_c = first_byte ? '0 : tlen_q;
		used_c = first_byte ? '0 : used_q;
		rs_c = first_byte ? '0 : rs_q;
		evcnt_c = first_byte ? '0 : evcnt_q;
		tempo_c = first_byte ? 1'b0 : tempo_q;
		fa = {acc_c[23:0], b};
		fl = (left_c != 3'd0) ? left_c - 3'd1 : 3'd0;
		fdone = fl == 3'd0;
		va = {acc_c[24:0], b[6:0]};
		vdone = !b[7];
		ph_n = ph_c; acc_n = acc_c; left_n = left_c; ntrk_n = ntrk_c;
		chunk_n = chunk_c; tlen_n = tlen_c; rs_n = rs_c; evcnt_n = evcnt_c;
		tempo_n = tempo_c;
		cs_n = first_byte ? '0 : cs_q;
		edelta_n = first_byte ? '0 : edelta_q;
		fd_n = first_byte ? '0 : fd_q;
		mt_n = first_byte ? '0 : mt_q;
		skip_n = first_byte ? '0 : skip_q;
		used_n = used_c;
		if (ph_c >= PH_DELTA && ph_c <= PH_TEMPO && used_c != 32'hffffffff)
			used_n = used_c + 32'd1;
		hi = cs_n[7:4];
		so = '0;
		// end_event / end_chunk handled through flags
		begin : fsm
			logic ev_end, ch_end, nxt;
			logic [31:0] sk;
			logic [4:0]  skph;
			logic        dostart;
			ev_end = 1'b0; ch_end = 1'b0; nxt = 1'b0;
			sk = '0; skph = PH_SKIP; dostart = 1'b0;
			case (ph_c)
				PH_MAGIC: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						if (fa == MAGIC_FILE) begin
							ph_n = PH_HLEN; left_n = 3'd4; acc_n = '0;
						end else begin
							so.cnt = 2'd1; so.r0.kind = K_NOFILE; ph_n = PH_IDLE;
						end
					end
				end
				PH_HLEN: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						if (fa == 32'd6) begin
							ph_n = PH_FORMAT; left_n = 3'd2; acc_n = '0;
						end else begin
							so.cnt = 2'd1; so.r0.kind = K_DONE; ph_n = PH_IDLE;
						end
					end
				end
				PH_FORMAT: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						ph_n = PH_NTRK; left_n = 3'd2; acc_n = '0;
					end
				end
				PH_NTRK: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						ntrk_n = fa[15:0]; ph_n = PH_DIV; left_n = 3'd2; acc_n = '0;
					end
				end
				PH_DIV: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						so.cnt = 2'd1; so.r0.kind = K_TPB; so.r0.value = {8'd0, fa[15:0]};
						chunk_n = '0; nxt = 1'b1;
					end
				end
				PH_CMAGIC: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						if (fa == MAGIC_TRACK) begin
							ph_n = PH_CLEN; left_n = 3'd4; acc_n = '0;
						end else ch_end = 1'b1;
					end
				end
				PH_CLEN: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						tlen_n = fa; used_n = '0; rs_n = '0;
						if (fa == 32'd0) ch_end = 1'b1;
						else begin
							ph_n = PH_DELTA; left_n = 3'd0; acc_n = '0;
						end
					end
				end
				PH_DELTA: begin
					acc_n = va;
					if (vdone) begin
						edelta_n = va; ph_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (!b[7]) begin
						if (rs_c == 8'd0) ev_end = 1'b1;
						else begin
							cs_n = rs_c; fd_n = b;
							if (rs_c[7:4] == 4'hc || rs_c[7:4] == 4'hd) ev_end = 1'b1;
							else ph_n = PH_DATA2;
						end
					end else if (b[7:4] != 4'hf) begin
						cs_n = b; rs_n = b; ph_n = PH_DATA1;
					end else begin
						rs_n = '0; cs_n = b;
						if (b == 8'hff) ph_n = PH_META_TYPE;
						else if (b == 8'hf0 || b == 8'hf7) begin
							ph_n = PH_SYSEX_LEN; left_n = 3'd0; acc_n = '0;
						end else ev_end = 1'b1;
					end
				end
				PH_DATA1: begin
					fd_n = b;
					if (hi == 4'hc || hi == 4'hd) ev_end = 1'b1;
					else ph_n = PH_DATA2;
				end
				PH_DATA2: begin
					if ((hi == 4'h8 || hi == 4'h9) && evcnt_c < max_events_q) begin
						so.cnt = 2'd1; so.r0.kind = K_NOTE; so.r0.delta = edelta_n;
						so.r0.status_byte = cs_n; so.r0.note = fd_n; so.r0.velocity = b;
						evcnt_n = evcnt_c + 16'd1;
					end
					ev_end = 1'b1;
				end
				PH_SYSEX_LEN: begin
					acc_n = va;
					if (vdone) begin
						dostart = 1'b1; sk = va;
					end
				end
				PH_META_TYPE: begin
					mt_n = b; ph_n = PH_META_LEN; left_n = 3'd0; acc_n = '0;
				end
				PH_META_LEN: begin
					acc_n = va;
					if (vdone) begin
						case (mt_n)
							8'h00: begin dostart = 1'b1; sk = 32'd2; end
							8'h20: begin dostart = 1'b1; sk = 32'd1; end
							8'h54: begin dostart = 1'b1; sk = 32'd5; end
							8'h58: begin dostart = 1'b1; sk = 32'd4; end
							8'h59: begin dostart = 1'b1; sk = 32'd2; end
							8'h2f: ch_end = 1'b1;
							8'h51: begin
								ph_n = PH_TEMPO; left_n = 3'd3; acc_n = '0;
							end
							8'h03: begin
								dostart = 1'b1; sk = va;
								skph = (chunk_c == 16'd0) ? PH_NAME : PH_SKIP;
							end
							default: begin dostart = 1'b1; sk = va; end
						endcase
					end
				end
				PH_NAME: begin
					so.cnt = 2'd1; so.r0.kind = K_NAME; so.r0.value = {16'd0, b};
					skip_n = skip_n - 32'd1;
					if (skip_n == 32'd0) ev_end = 1'b1;
				end
				PH_SKIP: begin
					skip_n = skip_n - 32'd1;
					if (skip_n == 32'd0) ev_end = 1'b1;
				end
				PH_TEMPO: begin
					acc_n = fa; left_n = fl;
					if (fdone) begin
						if (!tempo_c && fa[23:0] != 24'd0) begin
							so.cnt = 2'd1; so.r0.kind = K_TEMPO; so.r0.value = fa[23:0];
							tempo_n = 1'b1;
						end
						ev_end = 1'b1;
					end
				end
				default: ;
			endcase
			if (dostart) begin
				skip_n = sk;
				if (sk == 32'd0) ev_end = 1'b1;
				else ph_n = skph;
			end
			if (ev_end) begin
				if (used_n >= tlen_n) ch_end = 1'b1;
				else begin
					ph_n = PH_DELTA; left_n = 3'd0; acc_n = '0;
				end
			end
			if (ch_end) begin
				chunk_n = chunk_c + 16'd1; nxt = 1'b1;
			end
			if (nxt) begin
				if (chunk_n < ntrk_n && chunk_n < track_limit_q) begin
					ph_n = PH_CMAGIC; left_n = 3'd4; acc_n = '0;
				end else begin
					if (so.cnt == 2'd0) begin
						so.cnt = 2'd1; so.r0.kind = K_DONE;
					end else begin
						so.cnt = 2'd2; so.r1.kind = K_DONE;
					end
					ph_n = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; acc_q <= '0; left_q <= 3'd4; ntrk_q <= '0;
			chunk_q <= '0; tlen_q <= '0; used_q <= '0; rs_q <= '0; cs_q <= '0;
			edelta_q <= '0; fd_q <= '0; mt_q <= '0; skip_q <= '0; evcnt_q <= '0;
			tempo_q <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_n; acc_q <= acc_n; left_q <= left_n; ntrk_q <= ntrk_n;
			chunk_q <= chunk_n; tlen_q <= tlen_n; used_q <= used_n; rs_q <= rs_n;
			cs_q <= cs_n; edelta_q <= edelta_n; fd_q <= fd_n; mt_q <= mt_n;
			skip_q <= skip_n; evcnt_q <= evcnt_n; tempo_q <= tempo_n;
		end
	end

	mfne_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (so),
		.room2     (q_room),
		.empty     (q_empty),
		.pop       (out_valid && out_ready),
		.head      (head),
		.head_last (last_of_run)
	);

	assign out_valid = !q_empty;
	assign kind = head.kind;
	assign delta = head.delta;
	assign status_byte = head.status_byte;
	assign note = head.note;
	assign velocity = head.velocity;
	assign value = head.value;

	`MFNE_ASSERT(a_phase_range, clk, arst_n, (phase_q <= PH_IDLE))
	`MFNE_ASSERT_NEXT(a_idle_holds, clk, arst_n,
		(phase_q == PH_IDLE && !(accept && first_byte)), (phase_q == PH_IDLE))
	`MFNE_ASSERT(a_events_bounded, clk, arst_n,
		(!(accept && so.cnt != 2'd0 && so.r0.kind == K_NOTE) || evcnt_q < max_events_q
		|| first_byte))
endmodule
`default_nettype wire

// ----- tb/midi_file_note_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// midi_file_note_extractor_tb
// Streams generated midi files into the parser one byte per request and
// checks every result against a cycle-free parser model kept in this bench.
// Files are mostly well formed with random events, with bad magics, bad
// chunk headers, odd lengths and restarts mixed in. Both registers are
// rewritten between files while the parser is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module midi_file_note_extractor_tb;
	import mfne_pkg::*;

	localparam int BYTE_TARGET = 1750;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		res_t r;
		logic last;
	} parse_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, first_byte, out_valid, out_ready, last_of_run;
	logic [7:0] data_byte, status_byte, note, velocity;
	logic [2:0] kind;
	logic [31:0] delta, pwdata, prdata;
	logic [23:0] value;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;

	midi_file_note_extractor i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.first_byte(first_byte), .out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .delta(delta), .status_byte(status_byte), .note(note),
		.velocity(velocity), .value(value), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	parse_result_t expected_results[$];
	int mismatches, bytes_sent, results_seen, files_sent, cycles;
	bit idle_en;
	int stall_left;

	// parser model state
	logic [15:0] cfg_max_events, cfg_track_limit;
	logic [4:0] ph;
	logic [31:0] acc, trk_len, trk_used, ev_delta, skip_cnt;
	logic [2:0] left;
	logic [15:0] hdr_trk, chunk_cnt, note_cnt;
	logic [7:0] run_st, cur_st, first_d, meta_t;
	logic tempo_seen;
	res_t res_buf[2];
	int res_n;

	logic [7:0] file_q[$], body_q[$];
	logic [7:0] last_st;

	initial begin
		clk = 0;
		cycles = 0;
		forever begin
			#5 clk = ~clk;
			if (clk) begin
				cycles++;
				if (cycles > CYCLE_LIMIT) begin
					$display("timeout after %0d cycles", cycles);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	function automatic void clear_parser();
		ph = PH_MAGIC; acc = 0; left = 4; hdr_trk = 0; chunk_cnt = 0;
		trk_len = 0; trk_used = 0; run_st = 0; cur_st = 0; ev_delta = 0;
		first_d = 0; meta_t = 0; skip_cnt = 0; note_cnt = 0; tempo_seen = 0;
	endfunction

	function automatic void put_result(logic [2:0] k, logic [31:0] dl, logic [7:0] st,
			logic [7:0] nt, logic [7:0] vel, logic [23:0] val);
		if (res_n < 2) begin
			res_buf[res_n] = '{k, dl, st, nt, vel, val};
			res_n++;
		end
	endfunction

	function automatic void begin_field(logic [4:0] p, logic [2:0] n);
		ph = p; left = n; acc = 0;
	endfunction

	function automatic bit take_fixed(logic [7:0] b);
		acc = {acc[23:0], b};
		if (left > 0) left--;
		return left == 0;
	endfunction

	function automatic bit take_vlq(logic [7:0] b);
		acc = {acc[24:0], b[6:0]};
		return !b[7];
	endfunction

	function automatic void chunk_next();
		if (chunk_cnt < hdr_trk && chunk_cnt < cfg_track_limit) begin_field(PH_CMAGIC, 4);
		else begin
			put_result(K_DONE, 0, 0, 0, 0, 0);
			ph = PH_IDLE;
		end
	endfunction

	function automatic void chunk_end();
		chunk_cnt++;
		chunk_next();
	endfunction

	function automatic void event_end();
		if (trk_used >= trk_len) chunk_end();
		else begin_field(PH_DELTA, 0);
	endfunction

	function automatic void skip_start(logic [31:0] n, logic [4:0] p);
		skip_cnt = n;
		if (n == 0) event_end();
		else ph = p;
	endfunction

	function automatic void data_first(logic [7:0] b);
		first_d = b;
		if (cur_st[7:4] == 4'hC || cur_st[7:4] == 4'hD) event_end();
		else ph = PH_DATA2;
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic first);
		logic [23:0] t;
		res_n = 0;
		if (first) clear_parser();
		if (ph >= PH_DELTA && ph <= PH_TEMPO && trk_used != '1) trk_used++;
		case (ph)
			PH_MAGIC: if (take_fixed(b)) begin
				if (acc == MAGIC_FILE) begin_field(PH_HLEN, 4);
				else begin
					put_result(K_NOFILE, 0, 0, 0, 0, 0);
					ph = PH_IDLE;
				end
			end
			PH_HLEN: if (take_fixed(b)) begin
				if (acc == 6) begin_field(PH_FORMAT, 2);
				else begin
					put_result(K_DONE, 0, 0, 0, 0, 0);
					ph = PH_IDLE;
				end
			end
			PH_FORMAT: if (take_fixed(b)) begin_field(PH_NTRK, 2);
			PH_NTRK: if (take_fixed(b)) begin
				hdr_trk = acc[15:0];
				begin_field(PH_DIV, 2);
			end
			PH_DIV: if (take_fixed(b)) begin
				put_result(K_TPB, 0, 0, 0, 0, {8'h00, acc[15:0]});
				chunk_cnt = 0;
				chunk_next();
			end
			PH_CMAGIC: if (take_fixed(b)) begin
				if (acc == MAGIC_TRACK) begin_field(PH_CLEN, 4);
				else chunk_end();
			end
			PH_CLEN: if (take_fixed(b)) begin
				trk_len = acc;
				trk_used = 0;
				run_st = 0;
				if (trk_len == 0) chunk_end();
				else begin_field(PH_DELTA, 0);
			end
			PH_DELTA: if (take_vlq(b)) begin
				ev_delta = acc;
				ph = PH_STATUS;
			end
			PH_STATUS: begin
				if (!b[7]) begin
					if (run_st == 0) event_end();
					else begin
						cur_st = run_st;
						data_first(b);
					end
				end else if (b[7:4] != 4'hF) begin
					cur_st = b; run_st = b; ph = PH_DATA1;
				end else begin
					run_st = 0; cur_st = b;
					if (b == 8'hFF) ph = PH_META_TYPE;
					else if (b == 8'hF0 || b == 8'hF7) begin_field(PH_SYSEX_LEN, 0);
					else event_end();
				end
			end
			PH_DATA1: data_first(b);
			PH_DATA2: begin
				if ((cur_st[7:4] == 4'h8 || cur_st[7:4] == 4'h9) && note_cnt < cfg_max_events)
						begin
					put_result(K_NOTE, ev_delta, cur_st, first_d, b, 0);
					note_cnt++;
				end
				event_end();
			end
			PH_SYSEX_LEN: if (take_vlq(b)) skip_start(acc, PH_SKIP);
			PH_META_TYPE: begin
				meta_t = b;
				begin_field(PH_META_LEN, 0);
			end
			PH_META_LEN: if (take_vlq(b)) begin
				case (meta_t)
					8'h00: skip_start(2, PH_SKIP);
					8'h20: skip_start(1, PH_SKIP);
					8'h54: skip_start(5, PH_SKIP);
					8'h58: skip_start(4, PH_SKIP);
					8'h59: skip_start(2, PH_SKIP);
					8'h2F: chunk_end();
					8'h51: begin_field(PH_TEMPO, 3);
					8'h03: skip_start(acc, chunk_cnt == 0 ? PH_NAME : PH_SKIP);
					default: skip_start(acc, PH_SKIP);
				endcase
			end
			PH_NAME: begin
				put_result(K_NAME, 0, 0, 0, 0, {16'h0000, b});
				skip_cnt--;
				if (skip_cnt == 0) event_end();
			end
			PH_SKIP: begin
				skip_cnt--;
				if (skip_cnt == 0) event_end();
			end
			PH_TEMPO: if (take_fixed(b)) begin
				t = acc[23:0];
				if (!tempo_seen && t != 0) begin
					put_result(K_TEMPO, 0, 0, 0, 0, t);
					tempo_seen = 1;
				end
				event_end();
			end
			default: ;
		endcase
		for (int i = 0; i < res_n; i++)
			expected_results.push_back('{res_buf[i], i == res_n - 1});
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) report("unexpected result, kind", kind, 0);
			else begin
				e = expected_results.pop_front();
				if (kind !== e.r.kind) report("kind", kind, e.r.kind);
				if (delta !== e.r.delta) report("delta", delta, e.r.delta);
				if (status_byte !== e.r.status_byte) report("status", status_byte, e.r.status_byte);
				if (note !== e.r.note) report("note", note, e.r.note);
				if (velocity !== e.r.velocity) report("velocity", velocity, e.r.velocity);
				if (value !== e.r.value) report("value", value, e.r.value);
				if (last_of_run !== e.last) report("last_of_run", last_of_run, e.last);
			end
		end
	end

	// receiver stalls
	initial begin
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_ready <= 0;
			end else out_ready <= 1;
		end
	end

	task automatic send_byte(logic [7:0] b, logic first);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		first_byte <= first;
		do @(posedge clk); while (!in_ready);
		parse_byte(b, first);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == 0 || $urandom_range(0, 399) == 0);
		files_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] v);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, v};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_MAX_EVENTS) cfg_max_events = v;
		else cfg_track_limit = v;
		@(negedge clk);
	endtask

	function automatic void add_vlq(logic [31:0] v);
		logic [7:0] tmp[$];
		tmp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			tmp.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		foreach (tmp[i]) body_q.push_back(tmp[i]);
	endfunction

	function automatic void add_event();
		int r, n;
		logic [7:0] mt;
		r = $urandom_range(0, 9);
		if (r < 6) add_vlq($urandom_range(0, 200));
		else if (r < 9) add_vlq($urandom);
		else begin
			repeat (5) body_q.push_back(8'hFF);
			body_q.push_back(8'($urandom_range(0, 127)));
		end
		r = $urandom_range(0, 99);
		if (r < 50 && last_st != 0 && r >= 40 && last_st[7:4] != 4'hC && last_st[7:4] != 4'hD)
				begin
			body_q.push_back(8'($urandom_range(0, 127)));
			body_q.push_back(8'($urandom_range(0, 255)));
		end else if (r < 50) begin
			last_st = {$urandom_range(8, 9) == 8 ? 4'h8 : 4'h9, 4'($urandom)};
			body_q.push_back(last_st);
			body_q.push_back(8'($urandom_range(0, 127)));
			body_q.push_back(8'($urandom_range(0, 255)));
		end else if (r < 58) begin
			last_st = {4'($urandom_range(10, 14)), 4'($urandom)};
			body_q.push_back(last_st);
			body_q.push_back(8'($urandom_range(0, 127)));
			if (last_st[7:4] != 4'hC && last_st[7:4] != 4'hD)
				body_q.push_back(8'($urandom_range(0, 127)));
		end else if (r < 61) begin
			do mt = 8'hF0 | 8'($urandom_range(1, 14)); while (mt == 8'hF7);
			body_q.push_back(mt);
			last_st = 0;
		end else if (r < 65) begin
			body_q.push_back($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
			n = $urandom_range(0, 6);
			add_vlq(n);
			repeat (n) body_q.push_back(8'($urandom));
			last_st = 0;
		end else if (r < 90) begin
			last_st = 0;
			case ($urandom_range(0, 8))
				0: mt = 8'h00; 1: mt = 8'h20; 2: mt = 8'h54; 3: mt = 8'h58;
				4: mt = 8'h59; 5: mt = 8'h51; 6: mt = 8'h03; 7: mt = 8'h01;
				default: mt = 8'($urandom);
			endcase
			body_q.push_back(8'hFF);
			body_q.push_back(mt);
			case (mt)
				8'h00, 8'h59: n = 2;
				8'h20: n = 1;
				8'h54: n = 5;
				8'h58: n = 4;
				8'h51: n = 3;
				8'h2F: n = 0;
				default: n = $urandom_range(0, 8);
			endcase
			if (mt == 8'h51 || mt == 8'h03 || mt == 8'h2F || $urandom_range(0, 3) != 0)
				add_vlq(n);
			else add_vlq($urandom_range(0, 9));
			if (mt == 8'h51 && $urandom_range(0, 3) == 0) repeat (3) body_q.push_back(8'h00);
			else repeat (n) body_q.push_back(8'($urandom));
		end else begin
			if (last_st == 0) body_q.push_back(8'($urandom_range(0, 127)));
			else begin
				body_q.push_back(8'h90);
				body_q.push_back(8'($urandom_range(0, 127)));
				body_q.push_back(8'($urandom_range(0, 127)));
				last_st = 8'h90;
			end
		end
	endfunction

	function automatic void add_word(logic [31:0] w, int nb);
		for (int i = nb - 1; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
	endfunction

	function automatic void build_file();
		int ntrk, r, len;
		file_q.delete();
		add_word(MAGIC_FILE, 4);
		if ($urandom_range(0, 19) == 0) file_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
		add_word($urandom_range(0, 19) == 0 ? $urandom_range(0, 12) : 6, 4);
		add_word($urandom, 2);
		r = $urandom_range(0, 9);
		ntrk = r == 0 ? 0 : r < 8 ? r % 4 + 1 : r == 8 ? $urandom_range(4, 6) : $urandom;
		add_word(ntrk[15:0], 2);
		add_word($urandom, 2);
		for (int t = 0; t < ntrk && t < 4; t++) begin
			if ($urandom_range(0, 14) == 0) begin
				add_word($urandom, 4);
				continue;
			end
			body_q.delete();
			last_st = 0;
			repeat ($urandom_range(1, 10)) add_event();
			r = $urandom_range(0, 9);
			if (r < 7) begin
				body_q.push_back(8'h00); body_q.push_back(8'hFF);
				body_q.push_back(8'h2F); body_q.push_back(8'h00);
			end
			len = r == 9 ? 0 : r == 8 ? $urandom_range(1, body_q.size()) : body_q.size();
			if (r == 9) body_q.delete();
			add_word(MAGIC_TRACK, 4);
			add_word(len, 4);
			foreach (body_q[i]) file_q.push_back(body_q[i]);
		end
	endfunction

	task automatic test_bad_magic();
		file_q = '{8'h4d, 8'h54, 8'h68, 8'h65, 8'h00, 8'hFF};
		send_file();
		wait_idle();
	endtask

	task automatic test_bad_header_length();
		file_q = '{8'h4d, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h07, 8'h12};
		send_file();
		wait_idle();
	endtask

	task automatic test_chunk_cases();
		write_reg(REG_MAX_EVENTS, 16'd1);
		write_reg(REG_TRACK_LIMIT, 16'hFFFF);
		// zero length chunk, foreign chunk, then a chunk with tempo, wrapped delta
		// and a dropped note after the event limit
		file_q = '{8'h4d, 8'h54, 8'h68, 8'h64, 0, 0, 0, 6, 0, 1, 0, 3, 8'h01, 8'hE0,
			8'h4d, 8'h54, 8'h72, 8'h6b, 0, 0, 0, 0,
			8'h61, 8'h62, 8'h63, 8'h64,
			8'h4d, 8'h54, 8'h72, 8'h6b, 0, 0, 0, 8'h23,
			0, 8'hFF, 8'h03, 2, 8'h41, 8'h42,
			0, 8'hFF, 8'h51, 3, 0, 0, 0,
			0, 8'hFF, 8'h51, 3, 8'h07, 8'hA1, 8'h20,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h3C, 8'h64,
			0, 8'h3C, 0,
			0, 8'hFF, 8'h2F, 0};
		send_file();
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_MAX_EVENTS, 16'd0);
		repeat (2) begin
			build_file();
			send_file();
		end
		wait_idle();
		write_reg(REG_MAX_EVENTS, 16'hFFFF);
		write_reg(REG_TRACK_LIMIT, 16'd0);
		build_file();
		send_file();
		wait_idle();
	endtask

	task automatic test_random_files(int stop_at);
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: write_reg(REG_MAX_EVENTS, 16'hFFFF);
					1: write_reg(REG_MAX_EVENTS, 16'($urandom_range(0, 12)));
					default: write_reg(REG_MAX_EVENTS, 16'($urandom));
				endcase
				case ($urandom_range(0, 4))
					0: write_reg(REG_TRACK_LIMIT, 16'hFFFF);
					1: write_reg(REG_TRACK_LIMIT, 16'd0);
					default: write_reg(REG_TRACK_LIMIT, 16'($urandom_range(1, 4)));
				endcase
			end
			if ($urandom_range(0, 11) == 0) begin
				file_q.delete();
				repeat ($urandom_range(4, 16)) file_q.push_back(8'($urandom));
			end else build_file();
			send_file();
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0; data_byte = 0; first_byte = 0; out_ready = 1;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		mismatches = 0; bytes_sent = 0; results_seen = 0; files_sent = 0;
		idle_en = 1;
		cfg_max_events = MAX_EVENTS_RST;
		cfg_track_limit = TRACK_LIMIT_RST;
		clear_parser();
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_bad_magic();
		test_bad_header_length();
		test_chunk_cases();
		test_register_extremes();
		test_random_files(BYTE_TARGET - 250);
		idle_en = 0;
		test_random_files(BYTE_TARGET);
		wait_idle();
		repeat (10) @(negedge clk);
		$display("sent %0d bytes in %0d files, checked %0d results",
			bytes_sent, files_sent, results_seen);
		$display("covered headers, chunks, notes, tempo, names, sysex and meta skips");
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
